>>> hw/rtl/qscf_pkg.sv
// Shared types, constants and edge tables of the quadrilateral scanline filler.
package qscf_pkg;

	localparam int SCREEN_SIZE_DEF = 200;
	localparam int MAX_ROWS_DEF    = 64;

	// Quotient bits per divider cycle and number of divider cycles per row.
	localparam int DIV_BITS_PER_STEP = 2;
	localparam int DIV_STEPS         = 8 / DIV_BITS_PER_STEP;
	localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

	localparam int NUM_CORNER_REGS = 8;
	localparam int NUM_EDGES       = 4;

	// Corner points: inner_a, inner_b, outer_a, outer_b. Point p has its x in
	// corner register 2p and its y in register 2p+1.
	localparam logic [1:0] EDGE_P0 [NUM_EDGES] = '{2'd0, 2'd1, 2'd0, 2'd2};
	localparam logic [1:0] EDGE_P1 [NUM_EDGES] = '{2'd2, 2'd3, 2'd1, 2'd3};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_DIV,
		ST_PUSH
	} qscf_state_t;

	typedef struct packed {
		logic load;   // capture corners
		logic setup;  // find row range
		logic mul;    // start the edge crossings of the current row
		logic step;   // advance the edge dividers by one step
		logic push;   // write the span into the output register
	} qscf_cmd_t;

	typedef struct packed {
		logic out_free;  // output register can take a span this cycle
		logic last_row;  // current row is the final one
	} qscf_status_t;

endpackage

>>> hw/rtl/quad_scanline_checker_fill.sv
// Top level of the quadrilateral scanline filler with checkerboard start x.
//
// Input channel (s_*): one word carries the four corners of a quadrilateral,
// inner edge a/b and outer edge a/b. The outline runs inner_a, outer_a,
// outer_b, inner_b. s_tready is high only while the block is idle.
// Output channel (m_*): one word per row, from the least corner y upward,
// with the span bounds, an empty flag, the first lit x of the checkerboard
// and tlast on the final row. At most MAX_ROWS rows go out; when more rows
// were spanned, the last word also carries the clipped flag.
// Steps: capture and setup, then for each row the multiplier and the
// divider (two quotient bits a cycle) in each of the four side lanes,
// and a merge that loads the output register.
// A stalled receiver holds the output register and the sequencer waits in
// its push step; nothing is dropped. The next quadrilateral is taken while
// the final span still waits in the output register.
// Reset (arst_n low) drops any row walk in progress and empties the output.
module quad_scanline_checker_fill import qscf_pkg::*; #(
	parameter int SCREEN_SIZE = SCREEN_SIZE_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// inner_a_x, inner_a_y, inner_b_x, inner_b_y,
	// outer_a_x, outer_a_y, outer_b_x, outer_b_y (8 bits each)
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// row_y[7:0], span_left[15:8], span_right[24:16] (signed),
	// first_lit_x[32:25], zero fill [39:33]
	output logic [39:0] m_tdata,
	// row_empty[0], rows_clipped[1]
	output logic [1:0]  m_tuser,
	// last_row
	output logic        m_tlast
);

	qscf_cmd_t    cmd;
	qscf_status_t status;

	// Sequencer: owns the input handshake and steps each row through.
	qscf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: corners, row walk, edge lanes and the output register.
	qscf_datapath #(
		.SCREEN_SIZE (SCREEN_SIZE),
		.MAX_ROWS    (MAX_ROWS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTH
	// Accepting a quadrilateral starts the row walk; no second word right after.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again right after a capture");

	// Empty rows carry the screen-size marker and -1.
	a_empty_markers: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			m_tdata[15:8] == 8'(SCREEN_SIZE) && m_tdata[24:16] == 9'h1FF)
		else $error("empty row without its markers");

	// A row with a crossing has left bound at or below right bound.
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |->
			!m_tdata[24] && m_tdata[15:8] <= m_tdata[23:16])
		else $error("span bounds out of order");

	// Clipping is reported only on the final span.
	a_clip_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("clipped flag on a span that is not the last");
`endif

endmodule

>>> hw/rtl/qscf_edge.sv
// One edge lane: crossing test, multiplier and a two-bit-per-cycle divider.
module qscf_edge import qscf_pkg::*; (
	input  logic       clk,
	input  logic       mul,
	input  logic       step,
	input  logic [7:0] x0,
	input  logic [7:0] y0,
	input  logic [7:0] x1,
	input  logic [7:0] y1,
	input  logic [7:0] row,
	output logic       hit,
	output logic [7:0] x
);

	logic [7:0]  ymin, ymax, dy_row, dy_edge, adx;
	logic        neg, hit_d;
	logic [15:0] prod;
	logic        hit_q, neg_q;
	logic [7:0]  x0_q, div_q, rem_q, quo_q;
	logic [7:0]  rem_n, quo_n;
	logic [8:0]  trial;
	logic [8:0]  x_wide;

	always_comb begin
		ymin    = (y0 < y1) ? y0 : y1;
		ymax    = (y0 < y1) ? y1 : y0;
		hit_d   = (y0 != y1) && (row >= ymin) && (row <= ymax);
		dy_row  = (row >= y0) ? (row - y0) : (y0 - row);
		dy_edge = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
		neg     = (x1 < x0);
		adx     = neg ? (x0 - x1) : (x1 - x0);
		prod    = 16'(dy_row) * 16'(adx);
	end

	// Restoring division; the quotient never exceeds |x1 - x0|, so the high
	// byte of the product is already below the divisor.
	always_comb begin
		rem_n = rem_q;
		quo_n = quo_q;
		trial = '0;
		for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
			trial = {rem_n, quo_n[7]};
			quo_n = {quo_n[6:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				trial    = trial - {1'b0, div_q};
				quo_n[0] = 1'b1;
			end
			rem_n = trial[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mul) begin
			hit_q <= hit_d;
			neg_q <= neg;
			x0_q  <= x0;
			div_q <= dy_edge;
			rem_q <= prod[15:8];
			quo_q <= prod[7:0];
		end else if (step) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign x_wide = neg_q ? ({1'b0, x0_q} - {1'b0, quo_q}) : ({1'b0, x0_q} + {1'b0, quo_q});
	assign x      = x_wide[7:0];
	assign hit    = hit_q;

endmodule

>>> hw/rtl/qscf_datapath.sv
// Corner registers, row counter, four side lanes, span merge and output register.
module qscf_datapath import qscf_pkg::*; #(
	parameter int SCREEN_SIZE = SCREEN_SIZE_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  qscf_cmd_t    cmd,
	output qscf_status_t status,
	input  logic [63:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [39:0]  m_tdata,
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam logic [7:0] LAST_K = 8'(MAX_ROWS - 1);

	logic [7:0]    corner_q [NUM_CORNER_REGS];
	logic [7:0]    row_q;
	logic [RW-1:0] rows_left_q;
	logic          clipped_q;

	logic [7:0] ylo, yhi, span;
	logic       last;

	logic [NUM_EDGES-1:0] hit;
	logic [7:0]           xe [NUM_EDGES];

	logic       seen;
	logic [7:0] lo, hi, left;
	logic [8:0] right, first_w;
	logic [7:0] first;

	logic        out_valid_q;
	logic [39:0] out_data_q;
	logic [1:0]  out_user_q;
	logic        out_last_q;

	always_comb begin
		ylo = corner_q[1];
		yhi = corner_q[1];
		for (int p = 1; p < 4; p++) begin
			if (corner_q[2*p+1] < ylo) ylo = corner_q[2*p+1];
			if (corner_q[2*p+1] > yhi) yhi = corner_q[2*p+1];
		end
		span = yhi - ylo;
	end

	assign last = (rows_left_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < NUM_CORNER_REGS; i++) begin
				corner_q[i] <= s_tdata[8*i +: 8];
			end
		end
		if (cmd.setup) begin
			row_q       <= ylo;
			clipped_q   <= (span > LAST_K);
			rows_left_q <= (span > LAST_K) ? LAST_K[RW-1:0] : span[RW-1:0];
		end else if (cmd.push) begin
			row_q       <= row_q + 8'd1;
			rows_left_q <= rows_left_q - RW'(1);
		end
	end

	for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
		qscf_edge u_edge (
			.clk  (clk),
			.mul  (cmd.mul),
			.step (cmd.step),
			.x0   (corner_q[2*EDGE_P0[e]]),
			.y0   (corner_q[2*EDGE_P0[e]+1]),
			.x1   (corner_q[2*EDGE_P1[e]]),
			.y1   (corner_q[2*EDGE_P1[e]+1]),
			.row  (row_q),
			.hit  (hit[e]),
			.x    (xe[e])
		);
	end

	always_comb begin
		lo = 8'hFF;
		hi = 8'h00;
		for (int e = 0; e < NUM_EDGES; e++) begin
			if (hit[e] && xe[e] < lo) lo = xe[e];
			if (hit[e] && xe[e] > hi) hi = xe[e];
		end
		seen    = |hit;
		left    = seen ? lo : 8'(SCREEN_SIZE);
		right   = seen ? {1'b0, hi} : 9'h1FF;
		first_w = {1'b0, left} + {8'd0, left[0] ^ row_q[0]};
		first   = first_w[8] ? 8'hFF : first_w[7:0];
	end

	assign status.out_free = !out_valid_q || m_tready;
	assign status.last_row = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_data_q <= {7'd0, first, right, left, row_q};
			out_user_q <= {clipped_q && last, !seen};
			out_last_q <= last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

>>> hw/rtl/qscf_ctrl.sv
// Sequencer: input capture, row setup, per-row multiply, divide and push.
module qscf_ctrl import qscf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  qscf_status_t status,
	output qscf_cmd_t    cmd
);

	qscf_state_t          state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (status.out_free) begin
					cmd.push = 1'b1;
					state_d  = status.last_row ? ST_IDLE : ST_MUL;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> test/tb.sv
// Self-checking testbench for the quadrilateral scanline filler: random and directed corners.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Each cycle is 12 ns. The slowest legal run is about 235 quads, each with
	// 64 rows, each row followed by the longest receiver stall. Allow several
	// times that run before calling it a hang.
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_QUADS = 220;
	localparam int CALM_TAIL = 30;     // last quads go with no idling at all
	localparam int HOLD_AT = 120;      // span count that starts the long receiver hold
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 24;

	// Expected span of one row; field widths as on the output port.
	typedef struct packed {
		logic [7:0] row;
		logic [7:0] left;
		logic [8:0] right;
		logic [7:0] first;
		logic       empty;
		logic       clipped;
		logic       last;
	} span_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	quad_scanline_checker_fill dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	logic [63:0] corner_q [$];   // quads still to be offered, head is on the bus
	span_t       span_q [$];     // spans predicted and not yet seen
	int          total_quads = 0;
	int          words_in = 0;   // corner words accepted by the block
	int          spans_seen = 0; // span words accepted from the block
	int          errors = 0;
	int          cycles = 0;
	bit          calm;

	// No idling near the end of the run, and none in one stretch in the middle.
	assign calm = (words_in >= total_quads - CALM_TAIL) || (words_in >= 60 && words_in < 75);

	initial begin
		forever #6 clk = ~clk;
	end

	// Pack corners into the input word, inner_a_x in the lowest byte.
	function automatic logic [63:0] quad(input int iax, iay, ibx, iby, oax, oay, obx, oby);
		return {8'(oby), 8'(obx), 8'(oay), 8'(oax), 8'(iby), 8'(ibx), 8'(iay), 8'(iax)};
	endfunction

	// Walk the rows of one quad and queue the span that each emitted row should carry.
	task automatic predict_spans(input logic [63:0] w);
		int    px [4];
		int    py [4];
		int    ylo, yhi, total, count, y, lo, hi, left, right, first;
		int    a, b, x, ymin, ymax;
		bit    seen;
		span_t s;
		// points: 0 inner_a, 1 inner_b, 2 outer_a, 3 outer_b
		px[0] = w[7:0];   py[0] = w[15:8];
		px[1] = w[23:16]; py[1] = w[31:24];
		px[2] = w[39:32]; py[2] = w[47:40];
		px[3] = w[55:48]; py[3] = w[63:56];
		ylo = py[0];
		yhi = py[0];
		for (int p = 1; p < 4; p++) begin
			if (py[p] < ylo) ylo = py[p];
			if (py[p] > yhi) yhi = py[p];
		end
		total = yhi - ylo + 1;
		count = (total > 64) ? 64 : total;
		for (int k = 0; k < count; k++) begin
			y = ylo + k;
			seen = 0;
			lo = 0;
			hi = 0;
			for (int e = 0; e < 4; e++) begin
				// outline: inner_a-outer_a, inner_b-outer_b, inner_a-inner_b, outer_a-outer_b
				case (e)
					0: begin a = 0; b = 2; end
					1: begin a = 1; b = 3; end
					2: begin a = 0; b = 1; end
					default: begin a = 2; b = 3; end
				endcase
				ymin = (py[a] < py[b]) ? py[a] : py[b];
				ymax = (py[a] < py[b]) ? py[b] : py[a];
				// skip horizontal edges and edges that miss this row
				if (py[a] != py[b] && y >= ymin && y <= ymax) begin
					// int division truncates toward zero, as the block must
					x = px[a] + ((y - py[a]) * (px[b] - px[a])) / (py[b] - py[a]);
					if (!seen) begin
						lo = x;
						hi = x;
						seen = 1;
					end else begin
						if (x < lo) lo = x;
						if (x > hi) hi = x;
					end
				end
			end
			left = seen ? lo : 200;
			right = seen ? hi : -1;
			// checkerboard: bump to the next x when parity differs from the row's
			first = left + ((left ^ y) & 1);
			if (first > 255) first = 255;
			s.row = 8'(y);
			s.left = 8'(left);
			s.right = 9'(right);
			s.first = 8'(first);
			s.empty = !seen;
			s.clipped = (k == count - 1) && (total > count);
			s.last = (k == count - 1);
			span_q.push_back(s);
		end
	endtask

	task automatic check_field(input string name, input int expv, input int actv);
		if (expv != actv) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
			errors++;
		end
	endtask

	// Sample both handshakes at the rising edge: predict on every corner word,
	// check every span word against the oldest prediction.
	always @(posedge clk) begin
		span_t got;
		span_t want;
		cycles++;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_spans(s_tdata);
				words_in++;
			end
			if (m_tvalid && m_tready) begin
				spans_seen++;
				got.row = m_tdata[7:0];
				got.left = m_tdata[15:8];
				got.right = m_tdata[24:16];
				got.first = m_tdata[32:25];
				got.empty = m_tuser[0];
				got.clipped = m_tuser[1];
				got.last = m_tlast;
				if (span_q.size() == 0) begin
					$display("%0t: unexpected span word, expected none, actual row %0d",
						$time, got.row);
					errors++;
				end else begin
					want = span_q.pop_front();
					check_field("row_y", want.row, got.row);
					check_field("span_left", want.left, got.left);
					check_field("span_right", $signed(want.right), $signed(got.right));
					check_field("first_lit_x", want.first, got.first);
					check_field("row_empty", want.empty, got.empty);
					check_field("rows_clipped", want.clipped, got.clipped);
					check_field("last_row", want.last, got.last);
				end
			end
		end
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Corner driver: hold a word until taken, otherwise idle in random bursts.
	always @(negedge clk) begin
		logic        nv;
		logic [63:0] nd;
		int          gap_left;
		bit          took;
		int          words_popped;
		if (arst_n) begin
			took = (words_in != words_popped);
			nd = s_tdata;
			if (took) begin
				void'(corner_q.pop_front());
				words_popped++;
			end
			if (s_tvalid && !took) begin
				nv = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				nv = 1'b0;
			end else if (corner_q.size() == 0) begin
				nv = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(0, 15);
				nv = 1'b0;
			end else begin
				nv = 1'b1;
				nd = corner_q[0];
			end
			s_tvalid <= nv;
			s_tdata <= nd;
		end
	end

	// Span receiver: random stall bursts, plus one long hold that backs the block up.
	always @(negedge clk) begin
		logic nr;
		int   stall_left;
		int   hold_left;
		bit   held;
		if (arst_n) begin
			if (!held && spans_seen >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				held = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				nr = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				nr = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 15);
				nr = 1'b0;
			end else begin
				nr = 1'b1;
			end
			m_tready <= nr;
		end
	end

	initial begin
		int mode, ybase, yspan, ya, yb;
		int cy [4];
		int cx [4];

		// all corners on row 0: one empty row
		corner_q.push_back(quad(0, 0, 0, 0, 0, 0, 0, 0));
		// all corners at the far end: empty row 255, odd parity start
		corner_q.push_back(quad(255, 255, 255, 255, 255, 255, 255, 255));
		// flat quad with spread x: only horizontal edges, still empty
		corner_q.push_back(quad(3, 7, 90, 7, 150, 7, 199, 7));
		// ordinary convex quad
		corner_q.push_back(quad(50, 40, 60, 50, 90, 30, 100, 60));
		// exactly 64 rows, no clipping
		corner_q.push_back(quad(0, 0, 10, 63, 100, 0, 120, 63));
		// 65 rows, last one dropped and flagged
		corner_q.push_back(quad(0, 0, 10, 64, 100, 0, 120, 64));
		// full height and width: heavy clipping, extreme crossings
		corner_q.push_back(quad(0, 0, 0, 255, 255, 0, 255, 255));
		// crossings at x 255: even rows saturate the first lit x
		corner_q.push_back(quad(255, 0, 255, 4, 255, 0, 255, 4));
		// crossings beyond the nominal screen
		corner_q.push_back(quad(230, 210, 250, 240, 201, 220, 255, 230));
		// triangle: two corners coincide
		corner_q.push_back(quad(20, 10, 20, 10, 80, 40, 5, 33));
		// self-crossing outline
		corner_q.push_back(quad(10, 10, 100, 10, 100, 50, 10, 50));
		// falling slopes: negative products must truncate toward zero
		corner_q.push_back(quad(100, 0, 99, 7, 0, 7, 3, 0));
		// edges running from high y down to low y
		corner_q.push_back(quad(7, 60, 120, 58, 190, 3, 1, 5));
		// single tall sliver with odd and even parity rows
		corner_q.push_back(quad(1, 100, 2, 163, 1, 100, 2, 163));
		// bit patterns on every coordinate byte
		corner_q.push_back(quad(170, 85, 85, 170, 15, 240, 240, 15));

		for (int n = 0; n < RANDOM_QUADS; n++) begin
			mode = $urandom_range(0, 9);
			if (mode < 6) begin
				// well-formed quad on the screen with a moderate row count
				ybase = $urandom_range(0, 199);
				yspan = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 80)
					: $urandom_range(0, 40);
				for (int p = 0; p < 4; p++) begin
					cx[p] = $urandom_range(0, 199);
					cy[p] = ybase + $urandom_range(0, yspan);
					if (cy[p] > 255) cy[p] = 255;
				end
			end else if (mode < 8) begin
				// anything the byte fields allow
				for (int p = 0; p < 4; p++) begin
					cx[p] = $urandom_range(0, 255);
					cy[p] = $urandom_range(0, 255);
				end
			end else begin
				// degenerate: at most two distinct rows, shared x values
				ya = $urandom_range(0, 255);
				yb = ($urandom_range(0, 3) == 0) ? ya : $urandom_range(0, 255);
				for (int p = 0; p < 4; p++) begin
					cy[p] = $urandom_range(0, 1) ? ya : yb;
					cx[p] = $urandom_range(0, 1) ? 255 : $urandom_range(0, 255);
				end
			end
			corner_q.push_back(quad(cx[0], cy[0], cx[1], cy[1], cx[2], cy[2], cx[3], cy[3]));
		end
		total_quads = corner_q.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for all corners to go in and all spans to come out
		while (corner_q.size() != 0 || span_q.size() != 0 || s_tvalid) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
